@@ src/assert_macros.svh @@
// -----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent-assertion shorthands for the page table walker.
// -----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLIES(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle implication violated");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle implication violated");

`endif

@@ src/tlpt_pkg.sv @@
// -----------------------------------------------------------------------------
// tlpt_pkg
// Types and constants shared by the two-level page table walker.
// -----------------------------------------------------------------------------
`default_nettype none

package tlpt_pkg;

  localparam int DIRECTORIES_DEF = 4;
  localparam int POOL_TABLES_DEF = 64;

  localparam int ENTRIES     = 1024;   // entries per directory and per table
  localparam int IDX_W       = 10;     // directory / table index width
  localparam int OFFSET_W    = 12;     // page offset width
  localparam int DIR_SHIFT   = 22;     // directory index position in vaddr
  localparam int ADDR_W      = 32;
  localparam int FLAGS_W     = 12;
  localparam int DIR_ID_W    = 2;
  localparam int STATUS_W    = 2;
  localparam int FRAME_W     = ADDR_W - OFFSET_W;
  localparam int IN_DATA_W   = 80;     // dir_id, vaddr, paddr, flags, zero pad
  localparam int OUT_DATA_W  = 40;     // status, phys_result, zero pad
  localparam int OUT_PAD_W   = OUT_DATA_W - STATUS_W - ADDR_W;

  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(ENTRIES - 1);

  typedef enum logic {
    OP_MAP       = 1'b0,
    OP_TRANSLATE = 1'b1
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK         = 2'd0,
    ST_NOT_MAPPED = 2'd1,
    ST_EXHAUSTED  = 2'd2
  } status_t;

  // controller -> datapath
  typedef struct packed {
    logic    load_req;    // capture the incoming request
    logic    dclr_we;     // directory clear-pass write at the sweep counter
    logic    cnt_clr;
    logic    cnt_inc;
    logic    dir_link;    // link a fresh pool table into the directory entry
    logic    slot_ld;     // take the slot from the directory read data
    logic    tbl_clr_we;  // zero one leaf of the linked table
    logic    leaf_we;     // write the mapped leaf
    logic    res_ld;      // load the output register
    status_t res_status;
  } ctrl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic op_translate;
    logic dir_valid;
    logic pool_full;
    logic leaf_present;
    logic cnt_last_dir;
    logic cnt_last_tbl;
    logic out_busy;
  } dp_stat_t;

endpackage

`default_nettype wire

@@ src/two_level_page_table_map_translate.sv @@
// -----------------------------------------------------------------------------
// two_level_page_table_map_translate
// Map and translate requests against a two-level page table held on chip.
// -----------------------------------------------------------------------------
// Usage:
//  - Request channel s_axis_*: tuser is the operation (map or translate),
//    tdata carries directory id, virtual address, physical address, flags.
//  - Response channel m_axis_*: tdata carries status and translated address.
//  - After reset the directory store is swept clear, one entry per cycle, and
//    tready stays low meanwhile.
//  - One request is worked at a time. A walk reads the directory entry, then
//    for a translate the leaf; a map writes the leaf, but first links a new
//    table and zeroes it one leaf per cycle if the directory entry is empty.
//  - A new request is taken from the cycle after the previous response is
//    loaded, even while that response waits; a response that cannot be loaded
//    because the receiver stalls holds the walker until the output frees.
//  - Tables are never freed; when the pool is used up, a map that needs a new
//    table answers pool exhausted and changes nothing.
// -----------------------------------------------------------------------------
`default_nettype none

module two_level_page_table_map_translate #(
  parameter int DIRECTORIES = tlpt_pkg::DIRECTORIES_DEF,  // 1..16
  parameter int POOL_TABLES = tlpt_pkg::POOL_TABLES_DEF   // 1..1024
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  // dir_id[1:0], vaddr[33:2], paddr[65:34], page_flags[77:66]
  input  wire logic [tlpt_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // operation[0]
  input  wire logic [0:0]                      s_axis_tuser,
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  // status[1:0], phys_result[33:2]
  output logic [tlpt_pkg::OUT_DATA_W-1:0]      m_axis_tdata
);

  tlpt_pkg::ctrl_cmd_t cmd;
  tlpt_pkg::dp_stat_t  stat;

  // sequencer: clear pass, walk steps, response timing
  tlpt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // memories, allocation counter and output register
  tlpt_datapath #(
    .DIRECTORIES (DIRECTORIES),
    .POOL_TABLES (POOL_TABLES)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .stat     (stat),
    .s_tuser  (s_axis_tuser),
    .s_tdata  (s_axis_tdata),
    .m_tvalid (m_axis_tvalid),
    .m_tready (m_axis_tready),
    .m_tdata  (m_axis_tdata)
  );

endmodule

`default_nettype wire

@@ src/tlpt_ctrl.sv @@
// -----------------------------------------------------------------------------
// tlpt_ctrl
// Sequencer for directory clear, map and translate walks.
// -----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module tlpt_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire tlpt_pkg::dp_stat_t  stat,
  output tlpt_pkg::ctrl_cmd_t      cmd
);

  typedef enum logic [3:0] {
    S_CLEAR_DIR,
    S_IDLE,
    S_DIR_RD,
    S_DIR_CHK,
    S_CLEAR_TBL,
    S_LEAF_WR,
    S_LEAF_RD,
    S_LEAF_CHK,
    S_RESP
  } state_t;

  state_t            state;
  tlpt_pkg::status_t status_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR_DIR;
      status_q <= tlpt_pkg::ST_OK;
    end else begin
      unique case (state)
        S_CLEAR_DIR: begin
          if (stat.cnt_last_dir) state <= S_IDLE;
        end
        S_IDLE: begin
          if (in_valid) state <= S_DIR_RD;
        end
        S_DIR_RD: begin
          state <= S_DIR_CHK;
        end
        S_DIR_CHK: begin
          priority if (stat.dir_valid) begin
            state <= stat.op_translate ? S_LEAF_RD : S_LEAF_WR;
          end else if (stat.op_translate) begin
            status_q <= tlpt_pkg::ST_NOT_MAPPED;
            state    <= S_RESP;
          end else if (stat.pool_full) begin
            status_q <= tlpt_pkg::ST_EXHAUSTED;
            state    <= S_RESP;
          end else begin
            state <= S_CLEAR_TBL;
          end
        end
        S_CLEAR_TBL: begin
          if (stat.cnt_last_tbl) state <= S_LEAF_WR;
        end
        S_LEAF_WR: begin
          status_q <= tlpt_pkg::ST_OK;
          state    <= S_RESP;
        end
        S_LEAF_RD: begin
          state <= S_LEAF_CHK;
        end
        S_LEAF_CHK: begin
          status_q <= stat.leaf_present ? tlpt_pkg::ST_OK : tlpt_pkg::ST_NOT_MAPPED;
          state    <= S_RESP;
        end
        S_RESP: begin
          if (!stat.out_busy) state <= S_IDLE;
        end
        default: begin
          state <= S_CLEAR_DIR;
        end
      endcase
    end
  end

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd            = '0;
    cmd.res_status = status_q;
    unique case (state)
      S_CLEAR_DIR: begin
        cmd.dclr_we = 1'b1;
        cmd.cnt_inc = 1'b1;
        cmd.cnt_clr = stat.cnt_last_dir;
      end
      S_IDLE: begin
        cmd.load_req = in_valid;
      end
      S_DIR_CHK: begin
        if (stat.dir_valid) begin
          cmd.slot_ld = 1'b1;
        end else if (!stat.op_translate && !stat.pool_full) begin
          cmd.dir_link = 1'b1;
          cmd.cnt_clr  = 1'b1;
        end
      end
      S_CLEAR_TBL: begin
        cmd.tbl_clr_we = 1'b1;
        cmd.cnt_inc    = 1'b1;
        cmd.cnt_clr    = stat.cnt_last_tbl;
      end
      S_LEAF_WR: begin
        cmd.leaf_we = 1'b1;
      end
      S_RESP: begin
        cmd.res_ld = !stat.out_busy;
      end
      default: begin
      end
    endcase
  end

  `ASSERT_IMPLIES(a_res_no_overrun, clk, rst, cmd.res_ld, !stat.out_busy)
  `ASSERT_IMPLIES(a_link_has_room, clk, rst, cmd.dir_link, !stat.pool_full && !stat.dir_valid)

endmodule

`default_nettype wire

@@ src/tlpt_datapath.sv @@
// -----------------------------------------------------------------------------
// tlpt_datapath
// Request registers, directory and table pool memories, output register.
// -----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module tlpt_datapath #(
  parameter int DIRECTORIES = tlpt_pkg::DIRECTORIES_DEF,
  parameter int POOL_TABLES = tlpt_pkg::POOL_TABLES_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire tlpt_pkg::ctrl_cmd_t                cmd,
  output tlpt_pkg::dp_stat_t                      stat,
  input  wire logic [0:0]                         s_tuser,
  input  wire logic [tlpt_pkg::IN_DATA_W-1:0]     s_tdata,
  output logic                                    m_tvalid,
  input  wire logic                               m_tready,
  output logic [tlpt_pkg::OUT_DATA_W-1:0]         m_tdata
);

  localparam int DIR_W  = (DIRECTORIES > 1) ? $clog2(DIRECTORIES) : 1;
  localparam int SLOT_W = (POOL_TABLES > 1) ? $clog2(POOL_TABLES) : 1;
  localparam int CNT_W  = $clog2(POOL_TABLES + 1);
  localparam int DA_W   = DIR_W + tlpt_pkg::IDX_W;
  localparam int PA_W   = SLOT_W + tlpt_pkg::IDX_W;
  localparam int DIR_DEPTH  = DIRECTORIES * tlpt_pkg::ENTRIES;
  localparam int POOL_DEPTH = POOL_TABLES * tlpt_pkg::ENTRIES;
  localparam logic [DA_W-1:0] DIR_LAST = DA_W'(DIR_DEPTH - 1);

  // dir_id modulo DIRECTORIES on a 2-bit value
  function automatic logic [DIR_W-1:0] dir_fold(input logic [tlpt_pkg::DIR_ID_W-1:0] id);
    logic [4:0] v;
    v = {3'b000, id};
    for (int i = 0; i < 3; i++) begin
      if (v >= 5'(DIRECTORIES)) v = v - 5'(DIRECTORIES);
    end
    return v[DIR_W-1:0];
  endfunction

  // request registers
  tlpt_pkg::op_t                   op_q;
  logic [DIR_W-1:0]                dsel_q;
  logic [tlpt_pkg::ADDR_W-1:0]     vaddr_q;
  logic [tlpt_pkg::FRAME_W-1:0]    pframe_q;
  logic [tlpt_pkg::FLAGS_W-1:0]    flags_q;

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      op_q     <= tlpt_pkg::op_t'(s_tuser[0]);
      dsel_q   <= dir_fold(s_tdata[1:0]);
      vaddr_q  <= s_tdata[33:2];
      pframe_q <= s_tdata[65:46];   // paddr[31:12]
      flags_q  <= s_tdata[77:66];
    end
  end

  // sweep counter, shared by the directory clear and table clear
  logic [DA_W-1:0]   cnt;
  logic [CNT_W-1:0]  used;
  logic [SLOT_W-1:0] slot_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      used <= '0;
    end else begin
      if (cmd.cnt_clr) cnt <= '0;
      else if (cmd.cnt_inc) cnt <= cnt + 1'b1;
      if (cmd.dir_link) used <= used + 1'b1;
    end
  end

  // directory memory: {valid, slot}
  logic [SLOT_W:0]   dir_mem [DIR_DEPTH];
  logic [SLOT_W:0]   dir_rdata;
  logic [DA_W-1:0]   dir_addr;
  logic [DA_W-1:0]   dir_waddr;
  logic [SLOT_W:0]   dir_wdata;
  logic              dir_we;

  assign dir_addr  = {dsel_q, vaddr_q[tlpt_pkg::ADDR_W-1:tlpt_pkg::DIR_SHIFT]};
  assign dir_we    = cmd.dclr_we | cmd.dir_link;
  assign dir_waddr = cmd.dclr_we ? cnt : dir_addr;
  assign dir_wdata = cmd.dclr_we ? '0 : {1'b1, used[SLOT_W-1:0]};

  always_ff @(posedge clk) begin
    if (dir_we) dir_mem[dir_waddr] <= dir_wdata;
    dir_rdata <= dir_mem[dir_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.slot_ld) slot_q <= dir_rdata[SLOT_W-1:0];
    else if (cmd.dir_link) slot_q <= used[SLOT_W-1:0];
  end

  // table pool memory: leaf words
  logic [tlpt_pkg::ADDR_W-1:0] pool_mem [POOL_DEPTH];
  logic [tlpt_pkg::ADDR_W-1:0] leaf_q;
  logic [tlpt_pkg::ADDR_W-1:0] pool_wdata;
  logic [PA_W-1:0]             pool_addr;
  logic [PA_W-1:0]             pool_waddr;
  logic                        pool_we;

  assign pool_addr  = {slot_q, vaddr_q[tlpt_pkg::DIR_SHIFT-1:tlpt_pkg::OFFSET_W]};
  assign pool_we    = cmd.tbl_clr_we | cmd.leaf_we;
  assign pool_waddr = cmd.tbl_clr_we ? {slot_q, cnt[tlpt_pkg::IDX_W-1:0]} : pool_addr;
  assign pool_wdata = cmd.tbl_clr_we ? '0 : {pframe_q, flags_q};

  always_ff @(posedge clk) begin
    if (pool_we) pool_mem[pool_waddr] <= pool_wdata;
    leaf_q <= pool_mem[pool_addr];
  end

  // output register
  logic [tlpt_pkg::STATUS_W-1:0] out_status;
  logic [tlpt_pkg::ADDR_W-1:0]   out_phys;
  logic                          res_hit;

  assign res_hit = (cmd.res_status == tlpt_pkg::ST_OK) && (op_q == tlpt_pkg::OP_TRANSLATE);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.res_ld) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_ld) begin
      out_status <= cmd.res_status;
      out_phys   <= res_hit ? {leaf_q[tlpt_pkg::ADDR_W-1:tlpt_pkg::OFFSET_W],
                               vaddr_q[tlpt_pkg::OFFSET_W-1:0]} : '0;
    end
  end

  assign m_tdata = {{tlpt_pkg::OUT_PAD_W{1'b0}}, out_phys, out_status};

  assign stat.op_translate = (op_q == tlpt_pkg::OP_TRANSLATE);
  assign stat.dir_valid    = dir_rdata[SLOT_W];
  assign stat.pool_full    = (used >= CNT_W'(POOL_TABLES));
  assign stat.leaf_present = leaf_q[0];
  assign stat.cnt_last_dir = (cnt == DIR_LAST);
  assign stat.cnt_last_tbl = (cnt[tlpt_pkg::IDX_W-1:0] == tlpt_pkg::IDX_LAST);
  assign stat.out_busy     = m_tvalid & ~m_tready;

  `ASSERT_IMPLIES(a_used_bound, clk, rst, 1'b1, used <= CNT_W'(POOL_TABLES))
  `ASSERT_NEXT(a_link_counts, clk, rst, cmd.dir_link, used == $past(used) + 1'b1)

endmodule

`default_nettype wire

@@ tb/sv/tlpt_walk_checker.sv @@
// -----------------------------------------------------------------------------
// tlpt_walk_checker
// Watches both stream channels of the page table walker, keeps its own copy of
// the directories and the table pool, and compares every response in order.
// -----------------------------------------------------------------------------
`default_nettype none

module tlpt_walk_checker #(
  parameter int DIRECTORIES = tlpt_pkg::DIRECTORIES_DEF,
  parameter int POOL_TABLES = tlpt_pkg::POOL_TABLES_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            s_axis_tvalid,
  input  wire logic                            s_axis_tready,
  input  wire logic [tlpt_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  input  wire logic [0:0]                      s_axis_tuser,
  input  wire logic                            m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  input  wire logic [tlpt_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  output int                                   mismatches,
  output int                                   awaiting
);
  import tlpt_pkg::*;

  typedef struct packed {
    status_t           status;
    logic [ADDR_W-1:0] phys;
  } walk_result_t;

  walk_result_t      xlat_due_q[$];
  logic              pde_live  [DIRECTORIES*ENTRIES];
  int unsigned       pde_slot  [DIRECTORIES*ENTRIES];
  logic [ADDR_W-1:0] leaf_word [POOL_TABLES*ENTRIES];
  int unsigned       tables_taken;
  int                fail_tally = 0;

  task automatic report_mismatch(string what, logic [ADDR_W-1:0] got,
                                 logic [ADDR_W-1:0] want);
    $display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $realtime);
    fail_tally++;
  endtask

  // Applies one request to the shadow tables and returns the response it owes.
  function automatic walk_result_t walk_and_update(op_t op, logic [DIR_ID_W-1:0] did,
                                                   logic [ADDR_W-1:0] va,
                                                   logic [ADDR_W-1:0] pa,
                                                   logic [FLAGS_W-1:0] fl);
    int unsigned       pde;
    int unsigned       leaf_at;
    int                i;
    logic [ADDR_W-1:0] leaf;
    walk_result_t      r;
    pde = (int'(did) % DIRECTORIES) * ENTRIES + int'(va[ADDR_W-1:DIR_SHIFT]);
    r.status = ST_OK;
    r.phys   = '0;
    if (op == OP_MAP) begin
      if (!pde_live[pde]) begin
        if (tables_taken >= POOL_TABLES) begin
          r.status = ST_EXHAUSTED;
          return r;
        end
        for (i = 0; i < ENTRIES; i++)
          leaf_word[tables_taken*ENTRIES + i] = '0;
        pde_slot[pde] = tables_taken;
        pde_live[pde] = 1'b1;
        tables_taken++;
      end
      leaf_at = (pde_slot[pde] % POOL_TABLES) * ENTRIES + int'(va[DIR_SHIFT-1:OFFSET_W]);
      leaf_word[leaf_at] = {pa[ADDR_W-1:OFFSET_W], fl};
    end else begin
      if (!pde_live[pde]) begin
        r.status = ST_NOT_MAPPED;
      end else begin
        leaf_at = (pde_slot[pde] % POOL_TABLES) * ENTRIES + int'(va[DIR_SHIFT-1:OFFSET_W]);
        leaf = leaf_word[leaf_at];
        if (!leaf[0])
          r.status = ST_NOT_MAPPED;
        else
          r.phys = {leaf[ADDR_W-1:OFFSET_W], va[OFFSET_W-1:0]};
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin : watch
    walk_result_t got;
    walk_result_t want;
    int           k;
    if (rst) begin
      for (k = 0; k < DIRECTORIES*ENTRIES; k++)
        pde_live[k] = 1'b0;
      tables_taken = 0;
      xlat_due_q.delete();
    end else begin
      if (s_axis_tvalid && s_axis_tready)
        xlat_due_q.push_back(walk_and_update(op_t'(s_axis_tuser[0]),
                                             s_axis_tdata[DIR_ID_W-1:0],
                                             s_axis_tdata[DIR_ID_W +: ADDR_W],
                                             s_axis_tdata[DIR_ID_W+ADDR_W +: ADDR_W],
                                             s_axis_tdata[DIR_ID_W+2*ADDR_W +: FLAGS_W]));
      if (m_axis_tvalid && m_axis_tready) begin
        got.status = status_t'(m_axis_tdata[STATUS_W-1:0]);
        got.phys   = m_axis_tdata[STATUS_W +: ADDR_W];
        if (xlat_due_q.size() == 0) begin
          report_mismatch("response with no request outstanding", got.phys, '0);
        end else begin
          want = xlat_due_q.pop_front();
          if (got.status !== want.status)
            report_mismatch("status", ADDR_W'(got.status), ADDR_W'(want.status));
          if (got.phys !== want.phys)
            report_mismatch("phys_result", got.phys, want.phys);
        end
      end
    end
    mismatches <= fail_tally;
    awaiting   <= xlat_due_q.size();
  end

endmodule

`default_nettype wire

@@ tb/sv/tb.sv @@
// -----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the two-level page table walker: directed map and
// translate requests, then random ones biased toward pages already mapped.
// -----------------------------------------------------------------------------
`default_nettype none

module tb;
  import tlpt_pkg::*;

  // Slowest honest run: the directory sweep, 64 table links, ~420 requests
  // plus stalls, one RX_HOLD_CYCLES hold; the limit leaves ample margin.
  localparam int LIMIT_CYCLES   = 600000;
  localparam int RX_HOLD_CYCLES = 400;
  localparam int RANDOM_REQS    = 400;
  localparam int HOT_PDES       = 16;
  localparam int IDLE_PCT       = 15;
  localparam int TAIL_CYCLES    = 40;

  logic                  clk;
  logic                  rst;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata;   // dir_id, vaddr, paddr, page_flags
  logic [0:0]            s_axis_tuser;   // operation
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;   // status, phys_result

  int mismatches;
  int awaiting;
  int cycles;

  bit calm;           // no idling on either side while set
  bit stall_rx_req;   // asks the response side for one long hold-off

  // Pages mapped so far, as {dir_id, virtual page number}.
  logic [DIR_ID_W+FRAME_W-1:0] mapped_pages[$];
  logic [IDX_W-1:0]            hot_pde[HOT_PDES];

  two_level_page_table_map_translate dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  tlpt_walk_checker walk_chk (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .mismatches    (mismatches),
    .awaiting      (awaiting)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin : watchdog
    cycles = 0;
    while (cycles < LIMIT_CYCLES) begin
      @(posedge clk);
      cycles++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  // Offer one request from a falling edge and hold it until accepted. An
  // optional idle gap goes first; tvalid is only dropped when a gap is taken.
  task automatic send_request(op_t op, logic [DIR_ID_W-1:0] did, logic [ADDR_W-1:0] va,
                              logic [ADDR_W-1:0] pa, logic [FLAGS_W-1:0] fl);
    if (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      s_axis_tvalid = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tuser  = op;
    s_axis_tdata  = {2'b00, fl, pa, va, did};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    @(negedge clk);
  endtask

  // Block until every request sent so far has its response. The first look is
  // made after the clock rises so the checker's count matches the last accept.
  task automatic wait_drained();
    do @(posedge clk); while (awaiting != 0);
  endtask

  // Response side: random back-pressure, plus one long hold on request.
  initial begin : rx_side
    int hold_left;
    m_axis_tready = 1'b0;
    wait (!rst);
    @(negedge clk);
    forever begin
      if (stall_rx_req) begin
        m_axis_tready = 1'b0;
        for (hold_left = RX_HOLD_CYCLES; hold_left > 0; hold_left--)
          @(negedge clk);
        stall_rx_req = 1'b0;
      end else if (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
        m_axis_tready = 1'b0;
      end else begin
        m_axis_tready = 1'b1;
      end
      @(negedge clk);
    end
  end

  initial begin : stimulus
    int                 n;
    int                 pick;
    op_t                op;
    logic [DIR_ID_W-1:0] did;
    logic [ADDR_W-1:0]  va;
    logic [ADDR_W-1:0]  pa;
    logic [FLAGS_W-1:0] fl;

    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    calm          = 1'b0;
    stall_rx_req  = 1'b0;
    repeat (3) @(negedge clk);
    rst = 1'b0;

    // Directed part. The walker sweeps its directories first; the handshake
    // simply waits that out.
    send_request(OP_TRANSLATE, 2'd0, 32'h0000_0000, 32'h0, 12'h000);  // empty directory
    send_request(OP_MAP,       2'd0, 32'h0000_0000, 32'hFFFF_FFFF, 12'hFFF); // links a table
    send_request(OP_TRANSLATE, 2'd0, 32'h0000_0FFF, 32'h0, 12'h000);
    send_request(OP_TRANSLATE, 2'd0, 32'h0000_1000, 32'h0, 12'h000);  // cleared leaf
    send_request(OP_MAP,       2'd3, 32'hFFFF_FFFF, 32'h0000_0000, 12'h001);
    send_request(OP_TRANSLATE, 2'd3, 32'hFFFF_F000, 32'h0, 12'h000);
    send_request(OP_TRANSLATE, 2'd2, 32'hFFFF_FFFF, 32'h0, 12'h000);  // other directory
    // leaf written with present clear, then remapped present
    send_request(OP_MAP,       2'd3, 32'hFFFF_F123, 32'h1234_5678, 12'h000);
    send_request(OP_TRANSLATE, 2'd3, 32'hFFFF_FABC, 32'h0, 12'h000);
    send_request(OP_MAP,       2'd3, 32'hFFFF_F000, 32'hABCD_E000, 12'h003);
    send_request(OP_TRANSLATE, 2'd3, 32'hFFFF_F555, 32'h0, 12'h000);
    send_request(OP_MAP,       2'd1, 32'h1234_5678, 32'h8765_4321, 12'h801);
    send_request(OP_TRANSLATE, 2'd1, 32'h1234_5ABC, 32'h0, 12'h000);
    send_request(OP_TRANSLATE, 2'd1, 32'h1234_6678, 32'h0, 12'h000);  // same table, empty leaf
    send_request(OP_MAP,       2'd2, 32'h0040_0000, 32'h5555_5000, 12'hAAB);
    send_request(OP_TRANSLATE, 2'd2, 32'h0040_0FFF, 32'h0, 12'h000);
    send_request(OP_TRANSLATE, 2'd2, 32'h0000_0000, 32'h0, 12'h000);  // dir 2 entry 0 untouched
    mapped_pages.push_back({2'd0, 20'h00000});
    mapped_pages.push_back({2'd3, 20'hFFFFF});
    mapped_pages.push_back({2'd1, 20'h12345});
    mapped_pages.push_back({2'd2, 20'h00400});

    // Sender pauses here until the walker has answered everything.
    s_axis_tvalid = 1'b0;
    wait_drained();
    @(negedge clk);

    // Hot directory indexes: 16 of them over 4 directories is exactly the
    // pool size, so fresh random pages on top eventually exhaust the pool.
    hot_pde[0] = '0;
    hot_pde[1] = IDX_LAST;
    for (n = 2; n < HOT_PDES; n++)
      hot_pde[n] = IDX_W'($urandom_range(0, ENTRIES - 1));

    for (n = 0; n < RANDOM_REQS; n++) begin
      if (n == 60)
        stall_rx_req = 1'b1;   // long response hold while requests keep coming
      calm = (n >= 200 && n < 280);

      did  = DIR_ID_W'($urandom);
      va   = $urandom;
      pa   = $urandom;
      fl   = FLAGS_W'($urandom);
      pick = $urandom_range(0, 99);
      if ($urandom_range(0, 99) < 45) begin
        op = OP_MAP;
        if ($urandom_range(0, 99) < 80)
          fl[0] = 1'b1;
        if (pick < 20)
          {did, va[ADDR_W-1:OFFSET_W]} = mapped_pages[$urandom_range(0, mapped_pages.size() - 1)];
        else if (pick < 85)
          va[ADDR_W-1:DIR_SHIFT] = hot_pde[$urandom_range(0, HOT_PDES - 1)];
        mapped_pages.push_back({did, va[ADDR_W-1:OFFSET_W]});
      end else begin
        op = OP_TRANSLATE;
        if (pick < 65)
          {did, va[ADDR_W-1:OFFSET_W]} = mapped_pages[$urandom_range(0, mapped_pages.size() - 1)];
        else if (pick < 85)
          va[ADDR_W-1:DIR_SHIFT] = hot_pde[$urandom_range(0, HOT_PDES - 1)];
      end
      send_request(op, did, va, pa, fl);
    end
    calm = 1'b0;

    s_axis_tvalid = 1'b0;
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && awaiting == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule

`default_nettype wire
